### rtl/core/srq_pkg.sv
package srq_pkg;

   localparam int OP_W   = 2;
   localparam int KIND_W = 2;
   localparam int SEQ_W  = 32;
   localparam int TS_W   = 64;
   localparam int WORD_W = 32;
   localparam int MAXC_W = 8;

   localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
   localparam logic [OP_W-1:0] OP_ACK  = 2'd1;
   localparam logic [OP_W-1:0] OP_DUMP = 2'd2;

   localparam logic [KIND_W-1:0] KIND_PUSH  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ACK   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_REC   = 2'd2;
   localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd3;

   localparam logic [SEQ_W-1:0] SEQ_START = 32'd1;

   typedef struct packed {
      logic [SEQ_W-1:0]         seq;
      logic signed [TS_W-1:0]   stamp;
      logic [WORD_W-1:0]        resistance;
      logic [WORD_W-1:0]        voltage;
      logic                     ok;
   } rec_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      rec_type           rec;
      logic              dropped;
      logic              last;
   } resp_type;

endpackage

### rtl/core/srq_ram.sv
module srq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/sequenced_retransmit_queue.sv
// Push, acknowledge on an empty queue, empty dump: the result is registered and shown in the cycle after the transfer.
// Acknowledge: the walk reads records from the head and removes each whose sequence is at or below the
// acknowledged one; it stops at a newer record or when it removes every record, then gives the result.
// Dump: the first record is read from the head and registered out, then one record per cycle unless stalled.
// One item at a time; the walks are paced by the single read port of the record RAM.
// Synchronous reset empties the queue and sets the next sequence to 1; the RAM is not cleared.
module sequenced_retransmit_queue #(
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [srq_pkg::OP_W-1:0]              req_operation,
   input  logic signed [srq_pkg::TS_W-1:0]       req_timestamp,
   input  logic [srq_pkg::WORD_W-1:0]            req_resistance_word,
   input  logic [srq_pkg::WORD_W-1:0]            req_voltage_word,
   input  logic                                  req_measurement_ok,
   input  logic [srq_pkg::SEQ_W-1:0]             req_ack_sequence,
   input  logic [srq_pkg::MAXC_W-1:0]            req_max_count,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [srq_pkg::KIND_W-1:0]            rsp_kind,
   output logic [srq_pkg::SEQ_W-1:0]             rsp_sequence_res,
   output logic signed [srq_pkg::TS_W-1:0]       rsp_out_timestamp,
   output logic [srq_pkg::WORD_W-1:0]            rsp_out_resistance,
   output logic [srq_pkg::WORD_W-1:0]            rsp_out_voltage,
   output logic                                  rsp_out_ok,
   output logic [$clog2(DEPTH+1)-1:0]            rsp_entries_held,
   output logic                                  rsp_dropped_oldest,
   output logic [$clog2(DEPTH+1)-1:0]            rsp_removed_count,
   output logic                                  rsp_last
);

   import srq_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int NW = (CW > MAXC_W) ? CW : MAXC_W;
   localparam int RW = $bits(rec_type);

   typedef enum logic [1:0] {
      S_IDLE,
      S_ACK,
      S_DUMP
   } state_type;

   state_type           state_ff, state_in;
   logic [PW-1:0]       head_ff, head_in;
   logic [PW-1:0]       tail_ff, tail_in;
   logic [CW-1:0]       held_ff, held_in;
   logic [SEQ_W-1:0]    next_seq_ff, next_seq_in;
   logic [PW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic [SEQ_W-1:0]    ack_ff, ack_in;
   logic                rsp_valid_ff, rsp_valid_in;
   resp_type            rsp_ff, rsp_in;
   logic [CW-1:0]       rsp_entries_ff, rsp_entries_in;
   logic [CW-1:0]       rsp_removed_ff, rsp_removed_in;

   logic                out_free;
   logic                accept;
   logic                full;
   logic                ram_wr_en;
   logic                ram_rd_en;
   logic [PW-1:0]       ram_rd_addr;
   rec_type             wr_rec;
   logic [RW-1:0]       ram_rd_data;
   rec_type             rd_rec;
   logic [NW-1:0]       max_ext;
   logic [NW-1:0]       held_ext;
   logic [NW-1:0]       dump_n;
   logic [CW-1:0]       cnt_inc;

   function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
      return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !(state_ff == S_IDLE && out_free);
   assign accept    = req_valid && !req_stall;
   assign full      = (held_ff == CW'(DEPTH));

   assign wr_rec.seq        = next_seq_ff;
   assign wr_rec.stamp      = req_timestamp;
   assign wr_rec.resistance = req_resistance_word;
   assign wr_rec.voltage    = req_voltage_word;
   assign wr_rec.ok         = req_measurement_ok;

   assign rd_rec   = rec_type'(ram_rd_data);
   assign max_ext  = NW'(req_max_count);
   assign held_ext = NW'(held_ff);
   assign dump_n   = (max_ext < held_ext) ? max_ext : held_ext;
   assign cnt_inc  = cnt_ff + 1'b1;

   srq_ram #(
      .WIDTH (RW),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (tail_ff),
      .wr_data (wr_rec),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      state_in       = state_ff;
      head_in        = head_ff;
      tail_in        = tail_ff;
      held_in        = held_ff;
      next_seq_in    = next_seq_ff;
      rd_ptr_in      = rd_ptr_ff;
      cnt_in         = cnt_ff;
      ack_in         = ack_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_in         = rsp_ff;
      rsp_entries_in = rsp_entries_ff;
      rsp_removed_in = rsp_removed_ff;
      ram_wr_en      = 1'b0;
      ram_rd_en      = 1'b0;
      ram_rd_addr    = rd_ptr_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            ram_rd_addr = head_ff;
            if (accept) begin
               case (req_operation)
                  OP_PUSH: begin
                     ram_wr_en    = 1'b1;
                     tail_in      = ptr_next(tail_ff);
                     next_seq_in  = next_seq_ff + 1'b1;
                     rsp_valid_in = 1'b1;
                     rsp_in       = '0;
                     rsp_in.kind  = KIND_PUSH;
                     rsp_in.rec.seq = next_seq_ff;
                     rsp_in.last  = 1'b1;
                     rsp_removed_in = '0;
                     if (full) begin
                        head_in        = ptr_next(head_ff);
                        rsp_in.dropped = 1'b1;
                        rsp_entries_in = held_ff;
                     end else begin
                        held_in        = held_ff + 1'b1;
                        rsp_entries_in = held_ff + 1'b1;
                     end
                  end
                  OP_ACK: begin
                     ack_in = req_ack_sequence;
                     if (held_ff == '0) begin
                        rsp_valid_in   = 1'b1;
                        rsp_in         = '0;
                        rsp_in.kind    = KIND_ACK;
                        rsp_in.last    = 1'b1;
                        rsp_entries_in = '0;
                        rsp_removed_in = '0;
                     end else begin
                        ram_rd_en = 1'b1;
                        rd_ptr_in = head_ff;
                        cnt_in    = '0;
                        state_in  = S_ACK;
                     end
                  end
                  OP_DUMP: begin
                     if (dump_n == '0) begin
                        rsp_valid_in   = 1'b1;
                        rsp_in         = '0;
                        rsp_in.kind    = KIND_EMPTY;
                        rsp_in.last    = 1'b1;
                        rsp_entries_in = held_ff;
                        rsp_removed_in = '0;
                     end else begin
                        ram_rd_en = 1'b1;
                        rd_ptr_in = head_ff;
                        cnt_in    = CW'(dump_n);
                        state_in  = S_DUMP;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_ACK: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = ptr_next(rd_ptr_ff);
            if (rd_rec.seq <= ack_ff) begin
               rd_ptr_in = ptr_next(rd_ptr_ff);
               cnt_in    = cnt_inc;
               if (cnt_inc == held_ff) begin
                  head_in        = ptr_next(rd_ptr_ff);
                  held_in        = '0;
                  rsp_valid_in   = 1'b1;
                  rsp_in         = '0;
                  rsp_in.kind    = KIND_ACK;
                  rsp_in.last    = 1'b1;
                  rsp_entries_in = '0;
                  rsp_removed_in = cnt_inc;
                  state_in       = S_IDLE;
               end
            end else begin
               head_in        = rd_ptr_ff;
               held_in        = held_ff - cnt_ff;
               rsp_valid_in   = 1'b1;
               rsp_in         = '0;
               rsp_in.kind    = KIND_ACK;
               rsp_in.last    = 1'b1;
               rsp_entries_in = held_ff - cnt_ff;
               rsp_removed_in = cnt_ff;
               state_in       = S_IDLE;
            end
         end
         S_DUMP: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_in.kind    = KIND_REC;
               rsp_in.rec     = rd_rec;
               rsp_in.dropped = 1'b0;
               rsp_in.last    = (cnt_ff == CW'(1));
               rsp_entries_in = held_ff;
               rsp_removed_in = '0;
               cnt_in         = cnt_ff - 1'b1;
               if (cnt_ff == CW'(1)) begin
                  state_in = S_IDLE;
               end else begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = ptr_next(rd_ptr_ff);
                  rd_ptr_in   = ptr_next(rd_ptr_ff);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         held_ff      <= '0;
         next_seq_ff  <= SEQ_START;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         held_ff      <= held_in;
         next_seq_ff  <= next_seq_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rd_ptr_ff      <= rd_ptr_in;
      cnt_ff         <= cnt_in;
      ack_ff         <= ack_in;
      rsp_ff         <= rsp_in;
      rsp_entries_ff <= rsp_entries_in;
      rsp_removed_ff <= rsp_removed_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = rsp_ff.kind;
   assign rsp_sequence_res   = rsp_ff.rec.seq;
   assign rsp_out_timestamp  = rsp_ff.rec.stamp;
   assign rsp_out_resistance = rsp_ff.rec.resistance;
   assign rsp_out_voltage    = rsp_ff.rec.voltage;
   assign rsp_out_ok         = rsp_ff.rec.ok;
   assign rsp_entries_held   = rsp_entries_ff;
   assign rsp_dropped_oldest = rsp_ff.dropped;
   assign rsp_removed_count  = rsp_removed_ff;
   assign rsp_last           = rsp_ff.last;

   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      held_ff <= CW'(DEPTH))
      else $error("held count above depth");

   a_ptr_meet: assert property (@(posedge clock) disable iff (reset)
      (held_ff == '0 || held_ff == CW'(DEPTH)) |-> head_ff == tail_ff)
      else $error("head and tail disagree with held count");

   a_ack_out_empty: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_ACK |-> !rsp_valid_ff && cnt_ff < held_ff)
      else $error("acknowledge walk overlaps a pending result");

   a_push_seq: assert property (@(posedge clock) disable iff (reset)
      accept && req_operation == OP_PUSH |=> next_seq_ff == $past(next_seq_ff) + 1'b1)
      else $error("sequence not advanced by push");

   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.kind != KIND_REC |-> rsp_ff.last && state_ff == S_IDLE)
      else $error("non-record result without last");

endmodule
